@@ hw/rtl/mlft_pkg.sv @@
package mlft_pkg;

    // Switch port set: ports 0 .. NUM_PORTS-1, capped at the 16 mask bits
    localparam int NUM_PORTS = 16;
    localparam int MASK_W    = 16;
    localparam int PORT_W    = 4;
    localparam int ADDR_W    = 16;

    localparam logic [MASK_W-1:0] PORT_MASK_FULL =
        (NUM_PORTS >= MASK_W) ? {MASK_W{1'b1}}
                              : MASK_W'((32'd1 << NUM_PORTS) - 32'd1);

    // Frame header as it arrives
    typedef struct packed {
        logic [PORT_W-1:0] in_port;
        logic [ADDR_W-1:0] dest_addr;
        logic [ADDR_W-1:0] src_addr;
    } t_hdr;

    // Forwarding decision
    typedef struct packed {
        logic [MASK_W-1:0] forward_mask;
        logic              learn_dropped;
    } t_fwd;

    // Lookup token handed from cell to cell
    typedef struct packed {
        logic [PORT_W-1:0] in_port;
        logic [ADDR_W-1:0] dest_addr;
        logic [ADDR_W-1:0] src_addr;
        logic              src_done;
        logic              dst_hit;
        logic [PORT_W-1:0] dst_port;
    } t_token;

endpackage

@@ hw/rtl/mlft_stream_if.sv @@
interface mlft_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/mlft_cell.sv @@
module mlft_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    input  logic            i_valid,
    input  mlft_pkg::t_token i_tok,
    output logic            o_valid,
    output mlft_pkg::t_token o_tok
);

    // Table entry held by this cell
    logic                          r_entry_valid;
    logic [mlft_pkg::ADDR_W-1:0]   r_entry_addr;
    logic [mlft_pkg::PORT_W-1:0]   r_entry_port;

    // Token stage register
    logic                          r_tok_valid;
    mlft_pkg::t_token              r_tok;

    logic                          n_entry_valid;
    logic [mlft_pkg::ADDR_W-1:0]   n_entry_addr;
    logic [mlft_pkg::PORT_W-1:0]   n_entry_port;
    mlft_pkg::t_token              n_tok;

    logic src_match;
    logic dst_match;
    logic learn_here;

    assign src_match = r_entry_valid && (r_entry_addr == i_tok.src_addr);
    assign dst_match = r_entry_valid && (r_entry_addr == i_tok.dest_addr);
    // Valid entries form a prefix, so the first free cell means the source is new
    assign learn_here = i_valid && !i_tok.src_done && (src_match || !r_entry_valid);

    // Learn and look up against this entry
    always_comb begin
        n_tok         = i_tok;
        n_entry_valid = r_entry_valid;
        n_entry_addr  = r_entry_addr;
        n_entry_port  = r_entry_port;
        if (learn_here) begin
            n_entry_valid = 1'b1;
            n_entry_addr  = i_tok.src_addr;
            n_entry_port  = i_tok.in_port;
            n_tok.src_done = 1'b1;
        end
        // Destination differs from source whenever it matters, so the old entry serves
        if (!i_tok.dst_hit && dst_match) begin
            n_tok.dst_hit  = 1'b1;
            n_tok.dst_port = r_entry_port;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= 1'b0;
            r_tok_valid   <= 1'b0;
        end else if (i_advance) begin
            r_entry_valid <= n_entry_valid;
            r_tok_valid   <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_entry_addr <= n_entry_addr;
            r_entry_port <= n_entry_port;
            r_tok        <= n_tok;
        end
    end

    assign o_valid = r_tok_valid;
    assign o_tok   = r_tok;

endmodule

@@ hw/rtl/mac_learning_forward_table_core.sv @@
// Learning forwarding table: a row of TABLE_SIZE cells, one table entry per cell.
// A token steps through the cells in order to the result, one cell per cycle while the row moves.
// Throughput: one header per cycle; a stalled result holds the whole row.
// Reset (synchronous, active low) clears every entry's valid bit and every token's
// valid bit; headers are taken once reset is released.
module mac_learning_forward_table_core #(
    parameter int TABLE_SIZE = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mlft_stream_if.sink          i_hdr,
    mlft_stream_if.source        o_fwd
);

    logic             advance;
    logic             w_valid [TABLE_SIZE+1];
    mlft_pkg::t_token w_tok   [TABLE_SIZE+1];
    mlft_pkg::t_token last_tok;
    mlft_pkg::t_fwd   fwd;

    // Whole row moves unless the result waits
    assign advance     = !w_valid[TABLE_SIZE] || o_fwd.ready;
    assign i_hdr.ready = advance;

    // Token entering the row
    always_comb begin
        w_tok[0]           = '0;
        w_tok[0].in_port   = i_hdr.data.in_port;
        w_tok[0].dest_addr = i_hdr.data.dest_addr;
        w_tok[0].src_addr  = i_hdr.data.src_addr;
    end
    assign w_valid[0] = i_hdr.valid;

    // Row of cells
    for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_cell
        mlft_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (advance),
            .i_valid   (w_valid[g]),
            .i_tok     (w_tok[g]),
            .o_valid   (w_valid[g+1]),
            .o_tok     (w_tok[g+1])
        );
    end

    assign last_tok = w_tok[TABLE_SIZE];

    // Port mask from the finished token
    always_comb begin
        fwd.learn_dropped = !last_tok.src_done;
        if (last_tok.dest_addr == last_tok.src_addr) begin
            fwd.forward_mask = '0;
        end else if (last_tok.dst_hit) begin
            fwd.forward_mask = (mlft_pkg::MASK_W'(1) << last_tok.dst_port)
                               & mlft_pkg::PORT_MASK_FULL;
        end else begin
            fwd.forward_mask = mlft_pkg::PORT_MASK_FULL
                               & ~(mlft_pkg::MASK_W'(1) << last_tok.in_port);
        end
    end

    assign o_fwd.valid = w_valid[TABLE_SIZE];
    assign o_fwd.data  = fwd;

endmodule

@@ hw/rtl/mlft_checker.sv @@
module mlft_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [mlft_pkg::MASK_W-1:0]   i_out_mask,
    input logic                          i_out_dropped
);

    // A waiting result holds steady
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_mask)
                                        && $stable(i_out_dropped))
        else $error("result changed while stalled");

    // With no result pending the row is free to move
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with empty output");

    // A stalled result stalls the input side
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input taken while output stalled");

    // Only existing ports are named in a mask
    a_mask_ports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_mask & ~mlft_pkg::PORT_MASK_FULL) == '0)
        else $error("mask names a port that does not exist");

endmodule

bind mac_learning_forward_table_core mlft_checker u_mlft_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_hdr.ready),
    .i_out_valid   (o_fwd.valid),
    .i_out_ready   (o_fwd.ready),
    .i_out_mask    (o_fwd.data.forward_mask),
    .i_out_dropped (o_fwd.data.learn_dropped)
);

@@ tb/sv/mac_learning_forward_table_core_test.sv @@
`timescale 1ns / 100ps

module mac_learning_forward_table_core_test;

    localparam int TABLE_SIZE = 64;
    localparam int POOL_SIZE  = 24;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mlft_stream_if #(.T(mlft_pkg::t_hdr)) hdr_if ();
    mlft_stream_if #(.T(mlft_pkg::t_fwd)) fwd_if ();

    mac_learning_forward_table_core #(
        .TABLE_SIZE (TABLE_SIZE)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hdr   (hdr_if),
        .o_fwd   (fwd_if)
    );

    // Clock
    always #5 i_clk = ~i_clk;

    // Shadow copy of the station table
    bit                          tbl_valid [TABLE_SIZE];
    logic [mlft_pkg::ADDR_W-1:0] tbl_addr [TABLE_SIZE];
    logic [mlft_pkg::PORT_W-1:0] tbl_port [TABLE_SIZE];

    mlft_pkg::t_fwd              fwd_expected [$];
    logic [mlft_pkg::ADDR_W-1:0] station_pool [POOL_SIZE];

    int fault_count   = 0;
    int hold_off_req  = 0;
    bit send_idle     = 1'b1;
    bit recv_idle     = 1'b1;

    // Mostly short gaps, a few long ones
    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int lookup_station(input logic [mlft_pkg::ADDR_W-1:0] addr);
        for (int i = 0; i < TABLE_SIZE; i++)
            if (tbl_valid[i] && tbl_addr[i] == addr)
                return i;
        return -1;
    endfunction

    function automatic int table_count();
        int n;
        n = 0;
        for (int i = 0; i < TABLE_SIZE; i++)
            if (tbl_valid[i])
                n++;
        return n;
    endfunction

    // Entries fill from the bottom and are never freed, so valid ones are contiguous
    function automatic logic [mlft_pkg::ADDR_W-1:0] known_station();
        return tbl_addr[$urandom_range(0, table_count() - 1)];
    endfunction

    function automatic logic [mlft_pkg::ADDR_W-1:0] fresh_station();
        logic [mlft_pkg::ADDR_W-1:0] a;
        do
            a = mlft_pkg::ADDR_W'($urandom_range(0, 65535));
        while (lookup_station(a) >= 0);
        return a;
    endfunction

    // Learn the source, then decide where the frame goes
    function automatic mlft_pkg::t_fwd learn_and_forward(input mlft_pkg::t_hdr h);
        mlft_pkg::t_fwd r;
        int   hit;
        int   free_idx;
        r.learn_dropped = 1'b0;
        hit = lookup_station(h.src_addr);
        if (hit >= 0) begin
            tbl_port[hit] = h.in_port;
        end else begin
            free_idx = -1;
            for (int i = TABLE_SIZE - 1; i >= 0; i--)
                if (!tbl_valid[i])
                    free_idx = i;
            if (free_idx >= 0) begin
                tbl_valid[free_idx] = 1'b1;
                tbl_addr[free_idx]  = h.src_addr;
                tbl_port[free_idx]  = h.in_port;
            end else begin
                r.learn_dropped = 1'b1;
            end
        end
        if (h.dest_addr == h.src_addr) begin
            r.forward_mask = '0;
        end else begin
            hit = lookup_station(h.dest_addr);
            if (hit >= 0)
                r.forward_mask = mlft_pkg::MASK_W'(32'd1 << tbl_port[hit])
                                 & mlft_pkg::PORT_MASK_FULL;
            else
                r.forward_mask = mlft_pkg::PORT_MASK_FULL
                                 & ~mlft_pkg::MASK_W'(32'd1 << h.in_port);
        end
        return r;
    endfunction

    // One header transfer; valid is left high for a back-to-back follow-up
    task automatic send_hdr(input logic [mlft_pkg::PORT_W-1:0] port,
                            input logic [mlft_pkg::ADDR_W-1:0] dst,
                            input logic [mlft_pkg::ADDR_W-1:0] src);
        mlft_pkg::t_hdr h;
        int   gap;
        h.in_port   = port;
        h.dest_addr = dst;
        h.src_addr  = src;
        gap = pick_gap(send_idle);
        @(negedge i_clk);
        if (gap > 0) begin
            hdr_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        hdr_if.valid <= 1'b1;
        hdr_if.data  <= h;
        @(posedge i_clk);
        while (!hdr_if.ready) @(posedge i_clk);
        fwd_expected.push_back(learn_and_forward(h));
    endtask

    // Sender pauses until every outstanding decision has come back
    task automatic wait_drained();
        @(negedge i_clk);
        hdr_if.valid <= 1'b0;
        while (fwd_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic note_fault(input string what, input logic [mlft_pkg::MASK_W-1:0] want,
                              input logic [mlft_pkg::MASK_W-1:0] got);
        fault_count++;
        if (fault_count <= 10)
            $display("%s mismatch: expected %h, got %h", what, want, got);
    endtask

    // Result side: random stalls plus an occasional long hold-off
    initial begin : fwd_ready_drive
        int stall_left;
        int hold_left;
        stall_left   = 0;
        hold_left    = 0;
        fwd_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req > 0) begin
                hold_left    = hold_off_req;
                hold_off_req = 0;
            end
            if (hold_left > 0) begin
                fwd_if.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                fwd_if.ready <= 1'b0;
                stall_left--;
            end else begin
                stall_left = pick_gap(recv_idle);
                if (stall_left > 0) begin
                    fwd_if.ready <= 1'b0;
                    stall_left--;
                end else begin
                    fwd_if.ready <= 1'b1;
                end
            end
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : fwd_check
        mlft_pkg::t_fwd want;
        if (i_rst_n === 1'b1 && fwd_if.valid === 1'b1 && fwd_if.ready === 1'b1) begin
            if (fwd_expected.size() == 0) begin
                note_fault("unexpected result", '0, fwd_if.data.forward_mask);
            end else begin
                want = fwd_expected.pop_front();
                if (fwd_if.data.forward_mask !== want.forward_mask)
                    note_fault("forward_mask", want.forward_mask, fwd_if.data.forward_mask);
                if (fwd_if.data.learn_dropped !== want.learn_dropped)
                    note_fault("learn_dropped", mlft_pkg::MASK_W'(want.learn_dropped),
                               mlft_pkg::MASK_W'(fwd_if.data.learn_dropped));
            end
        end
    end

    // Empty table: floods, drops on self-addressed frames, port moves
    task automatic test_empty_table();
        send_hdr(4'd0,  16'hFFFF, 16'h0000);
        send_hdr(4'd15, 16'h0000, 16'hFFFF);
        send_hdr(4'd3,  16'hFFFF, 16'h1234);
        send_hdr(4'd7,  16'h5A5A, 16'h5A5A);
        send_hdr(4'd9,  16'hA5A5, 16'h0000);
        send_hdr(4'd2,  16'h0000, 16'h1234);
        send_hdr(4'd2,  16'h1234, 16'h1234);
        send_hdr(4'd15, 16'hC3C3, 16'h3C3C);
        send_hdr(4'd8,  16'h3C3C, 16'h8000);
    endtask

    // Every port learned once, each frame sent to a station that is already learned
    task automatic test_port_sweep();
        for (int p = 0; p < 16; p++)
            send_hdr(mlft_pkg::PORT_W'(p),
                     (p == 0) ? 16'h8000 : mlft_pkg::ADDR_W'(16'h0100 + p - 1),
                     mlft_pkg::ADDR_W'(16'h0100 + p));
    endtask

    // Small address pool, so lookups mostly hit and ports keep moving
    task automatic test_pool_learning(input int count);
        logic [mlft_pkg::ADDR_W-1:0] src;
        logic [mlft_pkg::ADDR_W-1:0] dst;
        int                          r;
        for (int i = 0; i < POOL_SIZE; i++)
            station_pool[i] = mlft_pkg::ADDR_W'($urandom_range(0, 65535));
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) begin
                send_idle = ($urandom_range(0, 3) != 0);
                recv_idle = ($urandom_range(0, 3) != 0);
            end
            if (n == count / 2)
                wait_drained();
            src = ($urandom_range(0, 99) < 98) ? station_pool[$urandom_range(0, POOL_SIZE - 1)]
                                               : mlft_pkg::ADDR_W'($urandom_range(0, 65535));
            r = $urandom_range(0, 99);
            if (r < 50)
                dst = station_pool[$urandom_range(0, POOL_SIZE - 1)];
            else if (r < 70)
                dst = src;
            else if (r < 80)
                dst = known_station();
            else
                dst = mlft_pkg::ADDR_W'($urandom_range(0, 65535));
            send_hdr(mlft_pkg::PORT_W'($urandom_range(0, 15)), dst, src);
        end
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    // Long result hold-off with the sender pushing back to back
    task automatic test_output_hold_off(input int count);
        send_idle = 1'b0;
        hold_off_req = 300;
        for (int n = 0; n < count; n++)
            send_hdr(mlft_pkg::PORT_W'($urandom_range(0, 15)),
                     station_pool[$urandom_range(0, POOL_SIZE - 1)],
                     station_pool[$urandom_range(0, POOL_SIZE - 1)]);
        wait_drained();
        send_idle = 1'b1;
    endtask

    // Fill every entry, then show that new sources are no longer learned
    task automatic test_table_full();
        logic [mlft_pkg::ADDR_W-1:0] a;
        while (table_count() < TABLE_SIZE)
            send_hdr(mlft_pkg::PORT_W'($urandom_range(0, 15)), known_station(),
                     fresh_station());
        send_hdr(4'd4, known_station(), fresh_station());
        a = fresh_station();
        send_hdr(4'd11, a, a);
        send_hdr(4'd6, fresh_station(), known_station());
        send_hdr(4'd15, known_station(), known_station());
        send_hdr(4'd0, fresh_station(), fresh_station());
        send_hdr(4'd13, known_station(), 16'hFFFF);
    endtask

    // Full table: known sources move ports, unknown ones are dropped from learning
    task automatic test_full_table_random(input int count);
        logic [mlft_pkg::ADDR_W-1:0] src;
        logic [mlft_pkg::ADDR_W-1:0] dst;
        int                          r;
        for (int n = 0; n < count; n++) begin
            if (n % 120 == 0) begin
                send_idle = ($urandom_range(0, 3) != 0);
                recv_idle = ($urandom_range(0, 3) != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 50)
                src = known_station();
            else if (r < 90)
                src = mlft_pkg::ADDR_W'($urandom_range(0, 65535));
            else
                src = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            r = $urandom_range(0, 99);
            if (r < 40)
                dst = known_station();
            else if (r < 55)
                dst = src;
            else
                dst = mlft_pkg::ADDR_W'($urandom_range(0, 65535));
            send_hdr(mlft_pkg::PORT_W'($urandom_range(0, 15)), dst, src);
        end
        send_idle = 1'b1;
        recv_idle = 1'b1;
    endtask

    // Main sequence
    initial begin
        for (int i = 0; i < TABLE_SIZE; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_addr[i]  = '0;
            tbl_port[i]  = '0;
        end
        i_rst_n      = 1'b0;
        hdr_if.valid = 1'b0;
        hdr_if.data  = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_port_sweep();
        test_pool_learning(500);
        test_output_hold_off(100);
        test_table_full();
        test_full_table_random(770);

        wait_drained();
        repeat (2 * TABLE_SIZE) @(posedge i_clk);
        if (fault_count == 0 && fwd_expected.size() == 0)
            $display("PASS mac_learning_forward_table_core");
        else
            $display("FAIL mac_learning_forward_table_core");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("FAIL mac_learning_forward_table_core");
        $finish;
    end

endmodule

@@ mac_learning_forward_table_core.f @@
hw/rtl/mlft_pkg.sv
hw/rtl/mlft_stream_if.sv
hw/rtl/mlft_cell.sv
hw/rtl/mac_learning_forward_table_core.sv
hw/rtl/mlft_checker.sv
tb/sv/mac_learning_forward_table_core_test.sv
